FILE: rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the perspective point projection
// Widths of the camera-space math, the delta item and the divider lanes.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int W_COORD = 16;
    localparam int W_DELTA = 17;
    localparam int W_PROD  = 33;
    localparam int W_ROT   = 35;
    localparam int W_NUM   = 48;
    localparam int W_BIG   = 50;
    localparam int W_DVS   = 37;
    localparam int W_Q     = 17;
    localparam int W_CFG   = 48;
    localparam int W_SMALL = 10;
    localparam int W_ADDR  = 3;

    typedef enum logic [W_ADDR-1:0] {
        REG_CAMERA = 3'd0,
        REG_ROW0   = 3'd1,
        REG_ROW1   = 3'd2,
        REG_ROW2   = 3'd3,
        REG_FOCAL  = 3'd4,
        REG_CX     = 3'd5,
        REG_CY     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [W_DELTA-1:0] dz;
        logic signed [W_DELTA-1:0] dy;
        logic signed [W_DELTA-1:0] dx;
    } t_delta;

    // one axis of the restoring divider
    typedef struct packed {
        logic [W_DVS-1:0] rem;
        logic [W_DVS-1:0] dvs;
        logic [W_Q-1:0]   qb;
        logic             ovf;
        logic             neg;
    } t_div;

    // zero-depth fallback values carried next to the divider
    typedef struct packed {
        logic              zero;
        logic [W_COORD-1:0] zx;
        logic [W_COORD-1:0] zy;
    } t_side;

    function automatic logic signed [W_COORD-1:0] lane(input logic [W_CFG-1:0] pkt,
                                                      input int k);
        return pkt[W_COORD*k +: W_COORD];
    endfunction

    function automatic t_div div_init(input logic signed [W_NUM-1:0] n,
                                      input logic [W_ROT-1:0] den);
        t_div                       d;
        logic [W_NUM-1:0]           m;
        logic [W_BIG-1:0]           big;
        logic [W_BIG-W_Q-1:0]       hi;
        m   = n[W_NUM-1] ? W_NUM'(-n) : W_NUM'(n);
        big = {1'b0, m, 1'b0} + W_BIG'(den);
        hi  = big[W_BIG-1:W_Q];
        d.dvs = {1'b0, den, 1'b0};
        d.ovf = W_DVS'(hi) >= d.dvs;
        d.rem = d.ovf ? '0 : W_DVS'(hi);
        d.qb  = big[W_Q-1:0];
        d.neg = n[W_NUM-1];
        return d;
    endfunction

    function automatic t_div div_step(input t_div a);
        t_div           d;
        logic [W_DVS:0] r2;
        logic           ge;
        r2 = {a.rem, a.qb[W_Q-1]};
        ge = r2 >= {1'b0, a.dvs};
        d = a;
        d.rem = ge ? W_DVS'(r2 - {1'b0, a.dvs}) : W_DVS'(r2);
        d.qb  = {a.qb[W_Q-2:0], ge};
        return d;
    endfunction

    function automatic logic [W_COORD-1:0] div_finish(input t_div a);
        logic [W_COORD-1:0] v;
        if (a.neg) begin
            if (a.ovf || a.qb > W_Q'(32768)) v = 16'h8000;
            else v = W_COORD'(W_Q'(0) - a.qb);
        end else begin
            if (a.ovf || a.qb > W_Q'(32767)) v = 16'h7fff;
            else v = a.qb[W_COORD-1:0];
        end
        return v;
    endfunction

endpackage

FILE: rtl/ppp_front.sv
// ----------------------------------------------------------------------------
// ppp_front: request intake
// Take a point, subtract the camera position and push the delta.
// ----------------------------------------------------------------------------
module ppp_front (
    input  logic                                i_valid,
    input  logic signed [ppp_pkg::W_COORD-1:0]  i_point_x,
    input  logic signed [ppp_pkg::W_COORD-1:0]  i_point_y,
    input  logic signed [ppp_pkg::W_COORD-1:0]  i_point_z,
    input  logic [ppp_pkg::W_CFG-1:0]           i_cam,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output ppp_pkg::t_delta                     o_delta
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_delta.dx = ppp_pkg::W_DELTA'(i_point_x) - ppp_pkg::W_DELTA'(ppp_pkg::lane(i_cam, 0));
        o_delta.dy = ppp_pkg::W_DELTA'(i_point_y) - ppp_pkg::W_DELTA'(ppp_pkg::lane(i_cam, 1));
        o_delta.dz = ppp_pkg::W_DELTA'(i_point_z) - ppp_pkg::W_DELTA'(ppp_pkg::lane(i_cam, 2));
    end

endmodule

FILE: rtl/ppp_queue.sv
// ----------------------------------------------------------------------------
// ppp_queue: delta queue
// Small register FIFO between intake and the projection pipeline.
// ----------------------------------------------------------------------------
module ppp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppp_pkg::t_delta i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output ppp_pkg::t_delta o_data
);

    localparam int W_PTR = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CNT = $clog2(DEPTH + 1);

    ppp_pkg::t_delta  r_mem [DEPTH];
    logic [W_PTR-1:0] r_wr;
    logic [W_PTR-1:0] r_rd;
    logic [W_CNT-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = r_cnt == W_CNT'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == W_PTR'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == W_PTR'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && do_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/ppp_back.sv
// ----------------------------------------------------------------------------
// ppp_back: projection pipeline
// Rotate, form the rounded quotients with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module ppp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  ppp_pkg::t_delta                    i_q_data,
    output logic                               o_pop,
    input  logic [ppp_pkg::W_CFG-1:0]          i_row0,
    input  logic [ppp_pkg::W_CFG-1:0]          i_row1,
    input  logic [ppp_pkg::W_CFG-1:0]          i_row2,
    input  logic [ppp_pkg::W_SMALL-1:0]        i_focal,
    input  logic [ppp_pkg::W_SMALL-1:0]        i_cx,
    input  logic [ppp_pkg::W_SMALL-1:0]        i_cy,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [ppp_pkg::W_COORD-1:0] o_screen_x,
    output logic signed [ppp_pkg::W_COORD-1:0] o_screen_y,
    output logic                               o_zero_depth
);

    localparam int N_DIV = ppp_pkg::W_Q + 1;

    logic en;

    logic                                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [N_DIV-1:0]                     r_vd;
    logic                                 r_out_valid;
    logic signed [ppp_pkg::W_PROD-1:0]    r_p [3][3];
    logic signed [ppp_pkg::W_ROT-1:0]     r_r [3];
    logic [ppp_pkg::W_ROT-1:0]            r_den3, r_den4;
    logic signed [ppp_pkg::W_ROT-1:0]     r_cmpx, r_cmpy;
    logic [ppp_pkg::W_NUM-1:0]            r_ax, r_ay;
    logic signed [ppp_pkg::W_NUM-1:0]     r_bx, r_by;
    logic signed [ppp_pkg::W_NUM-1:0]     r_nx, r_ny;
    logic [ppp_pkg::W_ROT-1:0]            r_den5;
    ppp_pkg::t_side                       r_sd3, r_sd4, r_sd5;
    ppp_pkg::t_side                       r_sd [N_DIV];
    ppp_pkg::t_div                        r_dx [N_DIV];
    ppp_pkg::t_div                        r_dy [N_DIV];
    logic [ppp_pkg::W_COORD-1:0]          r_sx, r_sy;
    logic                                 r_zero;

    logic [ppp_pkg::W_CFG-1:0]            rows [3];
    logic signed [ppp_pkg::W_DELTA-1:0]   dv [3];
    logic signed [ppp_pkg::W_ROT-1:0]     rz;
    logic                                 rzneg;

    // hold everything while the output waits
    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en;

    assign rows[0] = i_row0;
    assign rows[1] = i_row1;
    assign rows[2] = i_row2;
    assign dv[0]   = i_q_data.dx;
    assign dv[1]   = i_q_data.dy;
    assign dv[2]   = i_q_data.dz;
    assign rz      = r_r[2];
    assign rzneg   = rz[ppp_pkg::W_ROT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_vd        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_q_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_vd        <= {r_vd[N_DIV-2:0], r_v5};
            r_out_valid <= r_vd[N_DIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= ppp_pkg::lane(rows[i], j) * dv[j];
                end
                r_r[i] <= ppp_pkg::W_ROT'(r_p[i][0]) + ppp_pkg::W_ROT'(r_p[i][1])
                        + ppp_pkg::W_ROT'(r_p[i][2]);
            end
            // fold the depth sign into the numerators
            r_den3       <= rzneg ? ppp_pkg::W_ROT'(-rz) : ppp_pkg::W_ROT'(rz);
            r_cmpx       <= rzneg ? r_r[0] : -r_r[0];
            r_cmpy       <= rzneg ? -r_r[1] : r_r[1];
            r_sd3.zero   <= rz == '0;
            r_sd3.zx     <= (r_r[0] > 0) ? 16'h8000 :
                            (r_r[0] < 0) ? 16'h7fff : ppp_pkg::W_COORD'(i_cx);
            r_sd3.zy     <= (r_r[1] > 0) ? 16'h7fff :
                            (r_r[1] < 0) ? 16'h8000 : ppp_pkg::W_COORD'(i_cy);
            r_ax   <= ppp_pkg::W_NUM'(i_cx) * ppp_pkg::W_NUM'(r_den3);
            r_ay   <= ppp_pkg::W_NUM'(i_cy) * ppp_pkg::W_NUM'(r_den3);
            r_bx   <= ppp_pkg::W_NUM'(r_cmpx) * $signed({1'b0, i_focal});
            r_by   <= ppp_pkg::W_NUM'(r_cmpy) * $signed({1'b0, i_focal});
            r_den4 <= r_den3;
            r_sd4  <= r_sd3;
            r_nx   <= $signed(r_ax) + r_bx;
            r_ny   <= $signed(r_ay) + r_by;
            r_den5 <= r_den4;
            r_sd5  <= r_sd4;
            r_dx[0] <= ppp_pkg::div_init(r_nx, r_den5);
            r_dy[0] <= ppp_pkg::div_init(r_ny, r_den5);
            r_sd[0] <= r_sd5;
            for (int k = 1; k < N_DIV; k++) begin
                r_dx[k] <= ppp_pkg::div_step(r_dx[k-1]);
                r_dy[k] <= ppp_pkg::div_step(r_dy[k-1]);
                r_sd[k] <= r_sd[k-1];
            end
            r_zero <= r_sd[N_DIV-1].zero;
            r_sx   <= r_sd[N_DIV-1].zero ? r_sd[N_DIV-1].zx
                                         : ppp_pkg::div_finish(r_dx[N_DIV-1]);
            r_sy   <= r_sd[N_DIV-1].zero ? r_sd[N_DIV-1].zy
                                         : ppp_pkg::div_finish(r_dy[N_DIV-1]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_screen_x   = r_sx;
    assign o_screen_y   = r_sy;
    assign o_zero_depth = r_zero;

endmodule

FILE: rtl/perspective_point_projection_top.sv
// Throughput: one request per cycle while the output is not stalled; the
// 17-step restoring divider is pipelined.
// The back pipeline stalls as a whole only while a finished result is held.
// Reset (synchronous, active low) empties the queue and pipeline and loads
// the identity matrix, a zero camera, focal 120 and center (64, 16).
// ----------------------------------------------------------------------------
// perspective_point_projection_top: 3D point to screen projection
// Config registers, intake, delta queue and projection pipeline.
// ----------------------------------------------------------------------------
module perspective_point_projection_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppp_pkg::W_ADDR-1:0]         i_cfg_addr,
    input  logic [ppp_pkg::W_CFG-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [ppp_pkg::W_COORD-1:0] i_point_x,
    input  logic signed [ppp_pkg::W_COORD-1:0] i_point_y,
    input  logic signed [ppp_pkg::W_COORD-1:0] i_point_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [ppp_pkg::W_COORD-1:0] o_screen_x,
    output logic signed [ppp_pkg::W_COORD-1:0] o_screen_y,
    output logic                               o_zero_depth
);

    logic [ppp_pkg::W_CFG-1:0]   r_cam, r_row0, r_row1, r_row2;
    logic [ppp_pkg::W_SMALL-1:0] r_focal, r_cx, r_cy;

    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    ppp_pkg::t_delta q_in;
    ppp_pkg::t_delta q_out;

    // config writes land directly; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam   <= '0;
            r_row0  <= 48'h0000_0000_4000;
            r_row1  <= 48'h0000_4000_0000;
            r_row2  <= 48'h4000_0000_0000;
            r_focal <= 10'd120;
            r_cx    <= 10'd64;
            r_cy    <= 10'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ppp_pkg::REG_CAMERA: r_cam   <= i_cfg_data;
                ppp_pkg::REG_ROW0:   r_row0  <= i_cfg_data;
                ppp_pkg::REG_ROW1:   r_row1  <= i_cfg_data;
                ppp_pkg::REG_ROW2:   r_row2  <= i_cfg_data;
                ppp_pkg::REG_FOCAL:  r_focal <= i_cfg_data[ppp_pkg::W_SMALL-1:0];
                ppp_pkg::REG_CX:     r_cx    <= i_cfg_data[ppp_pkg::W_SMALL-1:0];
                ppp_pkg::REG_CY:     r_cy    <= i_cfg_data[ppp_pkg::W_SMALL-1:0];
                default: ;
            endcase
        end
    end

    // intake: stall only on a full queue, never on the output side
    ppp_front u_front (
        .i_valid   (i_valid),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_point_z (i_point_z),
        .i_cam     (r_cam),
        .i_full    (q_full),
        .o_stall   (o_stall),
        .o_push    (q_push),
        .o_delta   (q_in)
    );

    ppp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // projection: advance whenever the output register is free or taken
    ppp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_out),
        .o_pop        (q_pop),
        .i_row0       (r_row0),
        .i_row1       (r_row1),
        .i_row2       (r_row2),
        .i_focal      (r_focal),
        .i_cx         (r_cx),
        .i_cy         (r_cy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_zero_depth (o_zero_depth)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk)
        q_full |-> !q_push) else $error("push into full queue");
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");
    a_zero_x_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_depth) |-> (o_screen_x == 16'sh7fff ||
        o_screen_x == -16'sh8000 || o_screen_x == $signed({6'b0, r_cx})))
        else $error("bad screen x at zero depth");
    a_zero_y_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_depth) |-> (o_screen_y == 16'sh7fff ||
        o_screen_y == -16'sh8000 || o_screen_y == $signed({6'b0, r_cy})))
        else $error("bad screen y at zero depth");
`endif

endmodule

FILE: verif/perspective_point_projection_checker.sv
// ----------------------------------------------------------------------------
// perspective_point_projection_checker: projection scoreboard
// Mirrors the config registers, predicts each accepted request's screen point
// and compares the results in order.
// ----------------------------------------------------------------------------
module perspective_point_projection_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppp_pkg::W_ADDR-1:0]         i_cfg_addr,
    input  logic [ppp_pkg::W_CFG-1:0]          i_cfg_data,
    input  logic                               i_valid,
    input  logic                               i_stall_in,
    input  logic signed [15:0]                 i_point_x,
    input  logic signed [15:0]                 i_point_y,
    input  logic signed [15:0]                 i_point_z,
    input  logic                               i_res_valid,
    input  logic                               i_res_stall,
    input  logic signed [15:0]                 i_screen_x,
    input  logic signed [15:0]                 i_screen_y,
    input  logic                               i_zero_depth,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               zero;
    } t_screen;

    logic [47:0] cam, row [3];
    logic [9:0]  focal, cx, cy;
    t_screen     screen_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = screen_q.size();

    function automatic longint lane16(logic [47:0] p, int k);
        logic signed [15:0] v;
        v = p[16*k +: 16];
        return longint'(v);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // center + sgn*comp*f/rz, one rounding with halves away from zero
    function automatic longint project_axis(longint c, longint comp, longint sgn,
                                            longint f, longint rz);
        longint num, den, n, m, q;
        num = sgn * comp * f;
        den = rz;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        n = c * den + num;
        m = n < 0 ? -n : n;
        q = (2 * m + den) / (2 * den);
        return sat16(n < 0 ? -q : q);
    endfunction

    function automatic t_screen project_point(logic signed [15:0] px,
                                              logic signed [15:0] py,
                                              logic signed [15:0] pz);
        longint  d [3], r [3];
        t_screen s;
        d[0] = longint'(px) - lane16(cam, 0);
        d[1] = longint'(py) - lane16(cam, 1);
        d[2] = longint'(pz) - lane16(cam, 2);
        for (int i = 0; i < 3; i++) begin
            r[i] = 0;
            for (int j = 0; j < 3; j++) r[i] += lane16(row[i], j) * d[j];
        end
        s.zero = (r[2] == 0);
        if (s.zero) begin
            s.sx = 16'(r[0] > 0 ? -32768 : (r[0] < 0 ? 32767 : sat16(cx)));
            s.sy = 16'(r[1] > 0 ? 32767 : (r[1] < 0 ? -32768 : sat16(cy)));
        end else begin
            s.sx = 16'(project_axis(cx, r[0], -1, focal, r[2]));
            s.sy = 16'(project_axis(cy, r[1], 1, focal, r[2]));
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_screen got, want;
        if (!i_rst_n) begin
            cam    <= '0;
            row[0] <= 48'd16384;
            row[1] <= 48'h0000_4000_0000;
            row[2] <= 48'h4000_0000_0000;
            focal  <= 10'd120;
            cx     <= 10'd64;
            cy     <= 10'd16;
            fails  <= 0;
            screen_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (ppp_pkg::t_reg_idx'(i_cfg_addr))
                    ppp_pkg::REG_CAMERA: cam    <= i_cfg_data;
                    ppp_pkg::REG_ROW0:   row[0] <= i_cfg_data;
                    ppp_pkg::REG_ROW1:   row[1] <= i_cfg_data;
                    ppp_pkg::REG_ROW2:   row[2] <= i_cfg_data;
                    ppp_pkg::REG_FOCAL:  focal  <= i_cfg_data[9:0];
                    ppp_pkg::REG_CX:     cx     <= i_cfg_data[9:0];
                    ppp_pkg::REG_CY:     cy     <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                screen_q.push_back(project_point(i_point_x, i_point_y, i_point_z));
            if (i_res_valid && !i_res_stall) begin
                got = '{i_screen_x, i_screen_y, i_zero_depth};
                if (screen_q.size() == 0) begin
                    if (fails < 10) $display("unexpected result %p", got);
                    fails <= fails + 1;
                end else begin
                    want = screen_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10)
                            $display("mismatch: expected x=%0d y=%0d z=%0b got x=%0d y=%0d z=%0b",
                                     want.sx, want.sy, want.zero, got.sx, got.sy, got.zero);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/perspective_point_projection_top_tb.sv
// ----------------------------------------------------------------------------
// perspective_point_projection_top_tb: projection block testbench
// Writes several camera/matrix/screen settings, streams directed and random
// points with random gaps and stalls, and lets the checker judge results.
// ----------------------------------------------------------------------------
module perspective_point_projection_top_tb;

    localparam int WATCHDOG = 20000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [ppp_pkg::W_ADDR-1:0]  cfg_addr = '0;
    logic [ppp_pkg::W_CFG-1:0]   cfg_data = '0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    logic signed [15:0]          pt_x = '0, pt_y = '0, pt_z = '0;
    logic                        res_valid;
    logic                        res_stall = 1'b0;
    logic signed [15:0]          scr_x, scr_y;
    logic                        scr_zero;
    int                          fail_count, pending;
    int                          idle_cycles = 0;
    bit                          hold_off = 1'b0;
    logic signed [15:0]          cam_z = '0;

    perspective_point_projection_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_screen_x(scr_x), .o_screen_y(scr_y), .o_zero_depth(scr_zero)
    );

    perspective_point_projection_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_stall_in(req_stall),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_screen_x(scr_x), .i_screen_y(scr_y), .i_zero_depth(scr_zero),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial forever #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, or one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        int n;
        if (hold_off) begin
            res_stall <= 1'b1;
        end else begin
            n = gap_len();
            res_stall <= (n != 0) && ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog: cycles with no handshake on either channel and no config write
    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("perspective_point_projection_top_tb failed");
            $finish;
        end
    end

    task automatic write_reg(ppp_pkg::t_reg_idx idx, logic [ppp_pkg::W_CFG-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // offer one request, hold it until accepted, maybe idle after
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        int g;
        req_valid <= 1'b1;
        pt_x <= x;
        pt_y <= y;
        pt_z <= z;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        g = gap_len();
        if (g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack3(logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [15:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r < 5) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    function automatic logic [15:0] rand_rot();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return 16'h0000;
        if (r == 3) return 16'h4000;
        if (r == 4) return 16'hc000;
        return 16'($urandom);
    endfunction

    task automatic random_config();
        logic [ppp_pkg::W_CFG-1:0] c;
        c = pack3(rand_coord(), rand_coord(), rand_coord());
        cam_z = c[47:32];
        write_reg(ppp_pkg::REG_CAMERA, c);
        write_reg(ppp_pkg::REG_ROW0, pack3(rand_rot(), rand_rot(), rand_rot()));
        write_reg(ppp_pkg::REG_ROW1, pack3(rand_rot(), rand_rot(), rand_rot()));
        write_reg(ppp_pkg::REG_ROW2, pack3(rand_rot(), rand_rot(), rand_rot()));
        write_reg(ppp_pkg::REG_FOCAL, 48'($urandom_range(0, 1023)));
        write_reg(ppp_pkg::REG_CX, 48'($urandom_range(0, 1023)));
        write_reg(ppp_pkg::REG_CY, 48'($urandom_range(0, 1023)));
    endtask

    task automatic random_points(int count);
        logic signed [15:0] x, y, z;
        for (int k = 0; k < count; k++) begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
            // sometimes place the point on the camera's depth plane
            if ($urandom_range(0, 15) == 0) z = cam_z;
            send_point(x, y, z);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, identity matrix
        send_point(16'sd0, 16'sd0, 16'sd256);
        send_point(16'sd256, 16'sd0, 16'sd0);
        send_point(-16'sd256, -16'sd256, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd100, -16'sd100, -16'sd256);
        send_point(16'sh7fff, 16'sh7fff, 16'sd1);
        send_point(16'sh8000, 16'sh8000, 16'sd1);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000);
        send_point(16'sd1, -16'sd1, 16'sh8000);
        send_point(16'sd128, 16'sd128, 16'sd256);
        drain();

        // extremes of the registers: focal zero, top centers, full matrix
        write_reg(ppp_pkg::REG_FOCAL, 48'd0);
        write_reg(ppp_pkg::REG_CX, 48'd1023);
        write_reg(ppp_pkg::REG_CY, 48'd1023);
        write_reg(ppp_pkg::REG_CAMERA, pack3(16'h8000, 16'h7fff, 16'h0100));
        write_reg(ppp_pkg::REG_ROW0, pack3(16'h7fff, 16'h8000, 16'h7fff));
        write_reg(ppp_pkg::REG_ROW1, pack3(16'h8000, 16'h7fff, 16'h8000));
        write_reg(ppp_pkg::REG_ROW2, pack3(16'h7fff, 16'h7fff, 16'h8000));
        send_point(16'sd3, 16'sd5, 16'sd7);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
        drain();
        write_reg(ppp_pkg::REG_FOCAL, 48'd1023);
        write_reg(ppp_pkg::REG_CX, 48'd0);
        write_reg(ppp_pkg::REG_CY, 48'd0);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sh8000, 16'sh7fff, 16'sh0100);
        drain();

        // long receiver hold-off while requests keep flowing
        write_reg(ppp_pkg::REG_ROW0, 48'd16384);
        write_reg(ppp_pkg::REG_ROW1, 48'h0000_4000_0000);
        write_reg(ppp_pkg::REG_ROW2, 48'h4000_0000_0000);
        write_reg(ppp_pkg::REG_CAMERA, 48'd0);
        hold_off <= 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                for (int k = 0; k < 40; k++) begin
                    req_valid <= 1'b1;
                    pt_x <= rand_coord();
                    pt_y <= rand_coord();
                    pt_z <= rand_coord();
                    @(posedge i_clk);
                    while (req_stall) @(posedge i_clk);
                end
                req_valid <= 1'b0;
            end
        join
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            @(posedge i_clk);
            random_points(200);
            drain();
        end

        if (fail_count == 0) begin
            $display("perspective_point_projection_top_tb passed");
        end else begin
            $display("perspective_point_projection_top_tb failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_queue.sv
rtl/ppp_back.sv
rtl/perspective_point_projection_top.sv
verif/perspective_point_projection_checker.sv
verif/perspective_point_projection_top_tb.sv
